@@ design/bounded_array_list_macros.svh @@
// assertion macros shared by the list design
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bal assertion failed");
`define BAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bal assertion failed");
`else
`define BAL_ASSERT_SAME(label, ante, cons)
`define BAL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/bal_pkg.sv @@
// types and constants for the bounded array list
`timescale 1ns / 1ps

package bal_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0]
    {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_FIND   = 2'd3
    } req_type_t;

    typedef enum logic [1:0]
    {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    localparam logic [7:0] CAPACITY_RESET = 8'd128;

endpackage

@@ design/bal_req_if.sv @@
// request channel: valid/ready plus request payload
`timescale 1ns / 1ps

interface bal_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic signed [bal_pkg::VALUE_W-1:0] value;
    logic [7:0]                    index;

    modport source (output valid, output req_type, output value, output index, input ready);
    modport sink (input valid, input req_type, input value, input index, output ready);
endinterface

@@ design/bal_rsp_if.sv @@
// response channel: valid/ready plus result payload
`timescale 1ns / 1ps

interface bal_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] found_index;
    logic [7:0] count;

    modport source (output valid, output status, output found_index, output count, input ready);
    modport sink (input valid, input status, input found_index, input count, output ready);
endinterface

@@ design/bal_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bounded_array_list.sv @@
// bounded ordered list of 32-bit values kept in a ram, walked by a small sequencer
//
//  channel   dir  handshake          payload
//  req       in   valid/ready        req_type, value, index
//  rsp       out  valid/ready        status, found_index, count
//  cfg       in   cfg_wr_en only     cfg_wr_data (capacity)
//
// one ram read and one ram write per cycle; every pass over entries moves one entry a cycle.
// append / insert at end: decide, put, resp; refused request or empty-list lookup: decide, resp.
// find: decide, then scan up to the match on a hit or over every entry on a miss, then resp.
// remove shifts the entries after the match down (shdn); insert at i shifts entries i and up (shup), then put.
// rst_n clears count and sets capacity to 128; ram contents are left as they are.
// a finished result waits in the output register while the next request is taken;
// the sequencer only stalls in its response state when that register is still full.
`timescale 1ns / 1ps
`include "bounded_array_list_macros.svh"

module bounded_array_list #(
    parameter int DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    bal_req_if.sink        req,
    bal_rsp_if.source      rsp,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = AW + 1;
    localparam int CMPW = (CW > 8) ? CW : 8;

    typedef enum logic [6:0]
    {
        ST_IDLE   = 7'b0000001,
        ST_DECIDE = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_SHDN   = 7'b0001000,
        ST_SHUP   = 7'b0010000,
        ST_PUT    = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [7:0]                   capacity_reg;
    bal_pkg::req_type_t           op_reg;
    logic [bal_pkg::VALUE_W-1:0]  value_reg;
    logic [7:0]                   pos_reg;
    logic [AW-1:0]                ptr_reg, ptr_next;
    bal_pkg::status_t             status_reg, status_next;
    logic [AW-1:0]                found_reg, found_next;
    logic                         out_valid_reg;
    bal_pkg::status_t             out_status_reg;
    logic [6:0]                   out_found_reg;
    logic [7:0]                   out_count_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [bal_pkg::VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [bal_pkg::VALUE_W-1:0]  ram_rdata;

    logic full, beyond, at_end, hit, scan_last, shdn_last, shup_last, out_free, req_xfer;

    bal_ram #(
        .WIDTH (bal_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign full      = (CMPW'(count_reg) >= CMPW'(capacity_reg)) || (count_reg >= CW'(DEPTH));
    assign beyond    = CMPW'(pos_reg) > CMPW'(count_reg);
    assign at_end    = CMPW'(pos_reg) == CMPW'(count_reg);
    assign hit       = (ram_rdata == value_reg);
    assign scan_last = (CW'(ptr_reg) + CW'(1)) == count_reg;
    assign shdn_last = (CW'(ptr_reg) + CW'(2)) == count_reg;
    assign shup_last = CMPW'(ptr_reg) == (CMPW'(pos_reg) + CMPW'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                status_next = bal_pkg::STAT_OK;
                found_next  = '0;
                case (op_reg)
                    bal_pkg::REQ_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = bal_pkg::STAT_FULL;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            ptr_next   = AW'(count_reg);
                            state_next = ST_PUT;
                        end
                    end
                    bal_pkg::REQ_INSERT:
                    begin
                        if (beyond)
                        begin
                            status_next = bal_pkg::STAT_RANGE;
                            state_next  = ST_RESP;
                        end
                        else if (full)
                        begin
                            status_next = bal_pkg::STAT_FULL;
                            state_next  = ST_RESP;
                        end
                        else if (at_end)
                        begin
                            ptr_next   = AW'(count_reg);
                            state_next = ST_PUT;
                        end
                        else
                        begin
                            // prefetch the last entry, shifting starts from the top
                            ram_raddr  = AW'(count_reg - CW'(1));
                            ptr_next   = AW'(count_reg);
                            state_next = ST_SHUP;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bal_pkg::STAT_MISSING;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                // always fetch the next entry; on a remove hit it feeds the first shift
                ram_raddr = AW'(ptr_reg + AW'(1));
                if (hit)
                begin
                    found_next = ptr_reg;
                    if (op_reg == bal_pkg::REQ_FIND)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (scan_last)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SHDN;
                    end
                end
                else if (scan_last)
                begin
                    status_next = bal_pkg::STAT_MISSING;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_SHDN:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = AW'(ptr_reg + AW'(2));
                if (shdn_last)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_SHUP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = AW'(ptr_reg - AW'(2));
                ptr_next  = ptr_reg - AW'(1);
                if (shup_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= bal_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (req_xfer)
        begin
            op_reg    <= bal_pkg::req_type_t'(req.req_type);
            value_reg <= req.value;
            pos_reg   <= req.index;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= 7'(found_reg);
            out_count_reg  <= 8'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.count       = out_count_reg;

    `BAL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `BAL_ASSERT_NEXT(a_accept_decide, req_xfer, state_reg == ST_DECIDE)
    `BAL_ASSERT_NEXT(a_idle_count, state_reg == ST_IDLE, $stable(count_reg))
    `BAL_ASSERT_NEXT(a_put_grows, state_reg == ST_PUT, count_reg == $past(count_reg) + CW'(1))
    `BAL_ASSERT_SAME(a_write_states, ram_we,
        (state_reg == ST_SHDN) || (state_reg == ST_SHUP) || (state_reg == ST_PUT))

endmodule
